FILE: rtl/tga_rle_pkg.sv
// Package with the shared types and constants of the TGA RLE pixel decoder.
package tga_rle_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_COMPRESSED_MODE = 2'd0;
  localparam logic [1:0] REG_ALPHA_PRESENT   = 2'd1;
  localparam logic [1:0] REG_PIXEL_TOTAL     = 2'd2;

  // Packet header decoding.
  localparam logic [7:0] RUN_HEADER_MIN = 8'd128;
  localparam logic [7:0] RUN_BIAS       = 8'd127;

  typedef struct packed {
    logic        compressed_mode;
    logic        alpha_present;
    logic [31:0] pixel_total;
  } cfg_t;

  typedef struct packed {
    logic        awaiting_header;
    logic        packet_is_run;
    logic [7:0]  packet_left;
    logic [1:0]  byte_slot;
    logic [23:0] color_hold;
    logic [31:0] pixels_done;
    logic        finished_flag;
    logic        error_flag;
  } state_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic [31:0] first_pixel;
    logic        image_done;
    logic        overflow_error;
  } result_t;

  localparam cfg_t CFG_RESET = '{
    compressed_mode: 1'b1,
    alpha_present:   1'b0,
    pixel_total:     32'd1
  };

  localparam state_t STATE_RESET = '{
    awaiting_header: 1'b1,
    packet_is_run:   1'b0,
    packet_left:     8'd0,
    byte_slot:       2'd0,
    color_hold:      24'd0,
    pixels_done:     32'd0,
    finished_flag:   1'b0,
    error_flag:      1'b0
  };

endpackage

FILE: rtl/tga_rle_if.sv
// Valid/ready stream interfaces for the decoder's byte input and pixel result channels.
interface tga_rle_in_if;
  logic       valid;
  logic       ready;
  logic       image_start;
  logic [7:0] data_byte;

  modport source (output valid, output image_start, output data_byte, input ready);
  modport sink (input valid, input image_start, input data_byte, output ready);
endinterface

interface tga_rle_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [7:0]  repeat_count;
  logic [31:0] first_pixel;
  logic        image_done;
  logic        overflow_error;

  modport source (
    output valid, output red, output green, output blue, output alpha,
    output repeat_count, output first_pixel, output image_done, output overflow_error,
    input ready
  );
  modport sink (
    input valid, input red, input green, input blue, input alpha,
    input repeat_count, input first_pixel, input image_done, input overflow_error,
    output ready
  );
endinterface

FILE: rtl/tga_rle_pixel_decoder_core.sv
// Top level of the TGA RLE pixel decoder: input stage, decode state and result register.
//
//   Channel     Direction  Handshake        Moves per transfer
//   in_stream   in         valid / ready    image_start, data_byte
//   out_stream  out        valid / ready    red, green, blue, alpha, repeat_count,
//                                           first_pixel, image_done, overflow_error
//   cfg_*       in         cfg_we only      register index and 32-bit write data
//
// One byte is taken per cycle while out_stream does not stall: the throughput is set
// by the single decode step between the input stage register and the result register.
// A byte is held in the input stage register, then decoded into the result register
// once that is free or emptying; its pixel is transferred out from there.
// Reset is synchronous on rst_n low and restores the configuration defaults and
// the decoder state of a fresh image.
// While a result waits on out_stream, one more byte is still taken into the
// input stage; only then does in_stream.ready drop.
module tga_rle_pixel_decoder_core (
  input  logic                clk,
  input  logic                rst_n,
  tga_rle_in_if.sink          in_stream,
  tga_rle_out_if.source       out_stream,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  // Configuration registers.
  tga_rle_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= tga_rle_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tga_rle_pkg::REG_COMPRESSED_MODE: cfg_r.compressed_mode <= cfg_wdata[0];
        tga_rle_pkg::REG_ALPHA_PRESENT:   cfg_r.alpha_present <= cfg_wdata[0];
        tga_rle_pkg::REG_PIXEL_TOTAL:     cfg_r.pixel_total <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input stage: one byte held ahead of the decode step.
  logic       stg_valid_r;
  logic       stg_start_r;
  logic [7:0] stg_byte_r;
  logic       out_valid_r;
  logic       adv;
  logic       fire;
  logic       in_fire;

  // The decode step may run whenever the result register is free or emptying.
  assign adv = !out_valid_r || out_stream.ready;
  assign fire = stg_valid_r && adv;
  assign in_stream.ready = !stg_valid_r || adv;
  assign in_fire = in_stream.valid && in_stream.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_stream.ready) begin
      stg_valid_r <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_start_r <= in_stream.image_start;
      stg_byte_r <= in_stream.data_byte;
    end
  end

  // Decoder state and the per-byte step.
  tga_rle_pkg::state_t  state_r;
  tga_rle_pkg::state_t  state_nxt;
  tga_rle_pkg::result_t result_nxt;
  tga_rle_pkg::result_t result_r;
  logic                 emit;

  tga_rle_step u_step (
    .cfg_i         (cfg_r),
    .state_i       (state_r),
    .image_start_i (stg_start_r),
    .data_byte_i   (stg_byte_r),
    .state_o       (state_nxt),
    .emit_o        (emit),
    .result_o      (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tga_rle_pkg::STATE_RESET;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      result_r <= result_nxt;
    end
  end

  assign out_stream.valid = out_valid_r;
  assign out_stream.red = result_r.red;
  assign out_stream.green = result_r.green;
  assign out_stream.blue = result_r.blue;
  assign out_stream.alpha = result_r.alpha;
  assign out_stream.repeat_count = result_r.repeat_count;
  assign out_stream.first_pixel = result_r.first_pixel;
  assign out_stream.image_done = result_r.image_done;
  assign out_stream.overflow_error = result_r.overflow_error;

  // An open packet always has pixels left in it.
  a_packet_open: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.awaiting_header |-> state_r.packet_left != 8'd0)
    else $error("open packet with no pixels left");

  // A result that finishes the image covers at least one pixel.
  a_done_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.image_done |-> result_r.repeat_count != 8'd0)
    else $error("image done on an empty result");

  // A result that covers no pixel is always an overflow.
  a_empty_is_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.repeat_count == 8'd0 |-> result_r.overflow_error)
    else $error("empty result without overflow flag");

  // The error flag is cleared only by the start of a new image.
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.error_flag && !(fire && stg_start_r) |=> state_r.error_flag)
    else $error("error flag dropped without image start");

endmodule

FILE: rtl/tga_rle_step.sv
// Next-state and result logic for one input byte (packet header or pixel data) of the TGA RLE decoder.
module tga_rle_step (
  input  tga_rle_pkg::cfg_t    cfg_i,
  input  tga_rle_pkg::state_t  state_i,
  input  logic                 image_start_i,
  input  logic [7:0]           data_byte_i,
  output tga_rle_pkg::state_t  state_o,
  output logic                 emit_o,
  output tga_rle_pkg::result_t result_o
);

  tga_rle_pkg::state_t s;
  tga_rle_pkg::state_t nxt;
  logic [23:0] take_color;
  logic [1:0]  take_slot;
  logic        take_done;
  logic [7:0]  wanted;
  logic [31:0] left_px;
  logic        over;
  logic [7:0]  n;
  logic        done_now;
  logic        emit;
  logic [7:0]  raw_left_dec;

  always_comb begin
    s = image_start_i ? tga_rle_pkg::STATE_RESET : state_i;
    nxt = s;
    emit = 1'b0;
    wanted = 8'd1;
    raw_left_dec = s.packet_left - 8'd1;

    // Byte collection into the B, G, R(, A) slots.
    take_color = s.color_hold;
    take_slot = 2'd0;
    take_done = 1'b0;
    case (s.byte_slot)
      2'd0: begin
        take_color[7:0] = data_byte_i;
        take_slot = 2'd1;
      end
      2'd1: begin
        take_color[15:8] = data_byte_i;
        take_slot = 2'd2;
      end
      2'd2: begin
        take_color[23:16] = data_byte_i;
        if (cfg_i.alpha_present) begin
          take_slot = 2'd3;
        end else begin
          take_done = 1'b1;
        end
      end
      default: begin
        take_done = 1'b1;
      end
    endcase

    if (!cfg_i.compressed_mode) begin
      if (!s.finished_flag) begin
        nxt.color_hold = take_color;
        nxt.byte_slot = take_slot;
        emit = take_done;
      end
    end else if (s.awaiting_header) begin
      if (!s.finished_flag) begin
        if (data_byte_i < tga_rle_pkg::RUN_HEADER_MIN) begin
          nxt.packet_is_run = 1'b0;
          nxt.packet_left = data_byte_i + 8'd1;
        end else begin
          nxt.packet_is_run = 1'b1;
          nxt.packet_left = data_byte_i - tga_rle_pkg::RUN_BIAS;
        end
        nxt.awaiting_header = 1'b0;
        nxt.byte_slot = 2'd0;
      end
    end else begin
      nxt.color_hold = take_color;
      nxt.byte_slot = take_slot;
      if (take_done) begin
        emit = 1'b1;
        if (s.packet_is_run) begin
          wanted = s.packet_left;
          nxt.packet_left = 8'd0;
          nxt.awaiting_header = 1'b1;
        end else begin
          nxt.packet_left = raw_left_dec;
          if (raw_left_dec == 8'd0) begin
            nxt.awaiting_header = 1'b1;
          end
        end
      end
    end

    // Clip against the pixels still left in the image.
    left_px = (cfg_i.pixel_total > s.pixels_done) ? (cfg_i.pixel_total - s.pixels_done) : 32'd0;
    over = {24'd0, wanted} > left_px;
    n = over ? left_px[7:0] : wanted;
    done_now = (n != 8'd0) && ({24'd0, n} == left_px);

    if (emit) begin
      if (over) begin
        nxt.error_flag = 1'b1;
      end
      nxt.pixels_done = s.pixels_done + {24'd0, n};
      if (done_now) begin
        nxt.finished_flag = 1'b1;
      end
    end

    state_o = nxt;
    emit_o = emit;
    result_o.red = nxt.color_hold[23:16];
    result_o.green = nxt.color_hold[15:8];
    result_o.blue = nxt.color_hold[7:0];
    result_o.alpha = cfg_i.alpha_present ? data_byte_i : 8'd0;
    result_o.repeat_count = n;
    result_o.first_pixel = s.pixels_done;
    result_o.image_done = done_now;
    result_o.overflow_error = nxt.error_flag;
  end

endmodule
